### design/ptrp_pkg.sv
`timescale 1ns / 1ps

package ptrp_pkg;

    // Field widths
    localparam int ADC_BITS   = 12;
    localparam int PWM_BITS   = 10;
    localparam int LVL_W      = 16;
    localparam int KMH_W      = 8;
    localparam int WEIGHT_W   = 9;
    localparam int SMOOTH_W   = ADC_BITS + 8;
    localparam int PROD_W     = 2 * LVL_W;

    // Serial arithmetic widths
    localparam int MPL_W      = LVL_W;
    localparam int ACC_W      = (ADC_BITS + 17 > PROD_W) ? ADC_BITS + 17 : PROD_W;
    localparam int NUM_W      = SMOOTH_W + LVL_W;
    localparam int DEN_W      = SMOOTH_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_FULL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_PER_MS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_MIN_STEP = 3'd5;

    // Constants
    localparam logic [LVL_W-1:0]    LVL_MAX        = {LVL_W{1'b1}};
    localparam logic [LVL_W-1:0]    ROUND_HALF     = LVL_MAX >> 1;
    localparam logic [WEIGHT_W-1:0] EMA_W_FULL     = 9'd256;
    localparam logic [8:0]          EMA_ROUND      = 9'd128;
    localparam logic [KMH_W-1:0]    LIMIT_KMH_MAX  = 8'd120;
    localparam logic [PWM_BITS-1:0] PWM_MAX        = {PWM_BITS{1'b1}};

    // Reset values of the registers
    localparam logic [WEIGHT_W-1:0] EMA_W_RST      = 9'd51;
    localparam logic [ADC_BITS-1:0] FULL_SCALE_RST = {ADC_BITS{1'b1}};
    localparam logic [LVL_W-1:0]    FLOOR_RST      = '0;
    localparam logic [LVL_W-1:0]    CEILING_RST    = LVL_MAX;
    localparam logic [LVL_W-1:0]    SLEW_RST       = 16'd66;
    localparam logic [LVL_W-1:0]    MIN_STEP_RST   = 16'd7;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_sample;
        logic                sample_fault;
        logic [LVL_W-1:0]    elapsed_ms;
        logic                limit_active;
        logic [KMH_W-1:0]    limit_kmh;
    } in_word_t;

    typedef struct packed {
        logic [PWM_BITS-1:0] pwm_duty;
        logic [LVL_W-1:0]    target_level;
        logic [LVL_W-1:0]    ramp_level;
        logic                sample_rejected;
    } out_word_t;

    // floor(p / 65535) for p < 65536*65535: p = a*65536 + b = a*65535 + (a + b)
    function automatic logic [LVL_W-1:0] div_by_lvl_max(input logic [PROD_W-1:0] p);
        logic [LVL_W:0] t;
        logic [LVL_W:0] q;
        t = {1'b0, p[PROD_W-1:LVL_W]} + {1'b0, p[LVL_W-1:0]};
        q = {1'b0, p[PROD_W-1:LVL_W]};
        if (t >= {LVL_MAX, 1'b0}) begin
            q = q + (LVL_W+1)'(2);
        end else if (t >= {1'b0, LVL_MAX}) begin
            q = q + (LVL_W+1)'(1);
        end
        return q[LVL_W-1:0];
    endfunction

endpackage

### design/ptrp_mul.sv
`timescale 1ns / 1ps

module ptrp_mul #(
    parameter int ACC_W = ptrp_pkg::ACC_W,
    parameter int MPL_W = ptrp_pkg::MPL_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACC_W-1:0] mcand,
    input  logic [MPL_W-1:0] mplier,
    input  logic [ACC_W-1:0] acc_init,
    output logic [ACC_W-1:0] acc,
    output logic             done
);

    logic             busy_reg,   busy_next;
    logic [ACC_W-1:0] acc_reg,    acc_next;
    logic [ACC_W-1:0] mcand_reg,  mcand_next;
    logic [MPL_W-1:0] mplier_reg, mplier_next;
    logic             last;

    // shift-add, one multiplier bit a cycle, stops once the multiplier is used up
    assign last = busy_reg && (mplier_reg == '0);

    always_comb begin
        busy_next   = busy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start) begin
            busy_next   = 1'b1;
            acc_next    = acc_init;
            mcand_next  = mcand;
            mplier_next = mplier;
        end else if (last) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign acc  = acc_reg;
    assign done = last;

endmodule

### design/ptrp_div.sv
`timescale 1ns / 1ps

module ptrp_div #(
    parameter int NUM_W = ptrp_pkg::NUM_W,
    parameter int DEN_W = ptrp_pkg::DEN_W,
    parameter int QUO_W = ptrp_pkg::LVL_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QUO_W-1:0] quo,
    output logic             ovf,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [NUM_W-1:0] num_reg,  num_next;
    logic [DEN_W-1:0] den_reg,  den_next;
    logic [DEN_W-1:0] rem_reg,  rem_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic             ovf_reg,  ovf_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // restoring division, one numerator bit a cycle
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            // quotient bits shifted out beyond the result width set the sticky overflow flag
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            quo_next = {quo_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign done = done_reg;

endmodule

### design/pedal_throttle_ramp_pwm.sv
// Channel | Ports                      | Word
// input   | s_valid s_ready s_data     | in_word_t: sample, fault, elapsed ms, zone limit
// result  | m_valid m_ready m_data     | out_word_t: pwm duty, target, ramp, rejected
// config  | cfg_we cfg_idx cfg_wdata   | one register per write, no wait
//
// One word at a time; a rejected sample with no elapsed time takes the shortest path.
// The 36-step serial divider (average normalize, zone cap) and the shift-add
// multiplier, one multiplier bit a cycle and done when the remaining bits are
// zero, set how long each word takes.
// Synchronous active-low reset clears control, the average and the ramp, and loads the registers' reset values.
// A new word is taken while a result waits in the output register; a stalled result
// holds the sequencer in its final state only.
`timescale 1ns / 1ps

module pedal_throttle_ramp_pwm (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ptrp_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [ptrp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ptrp_pkg::in_word_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ptrp_pkg::out_word_t                m_data
);

    import ptrp_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_EMA1 = 4'd1;
    localparam logic [3:0] ST_EMA2 = 4'd2;
    localparam logic [3:0] ST_NORM = 4'd3;
    localparam logic [3:0] ST_TMUL = 4'd4;
    localparam logic [3:0] ST_CMUL = 4'd5;
    localparam logic [3:0] ST_CDIV = 4'd6;
    localparam logic [3:0] ST_SLEW = 4'd7;
    localparam logic [3:0] ST_PWM  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // configuration registers
    logic [WEIGHT_W-1:0] weight_reg;
    logic [ADC_BITS-1:0] fs_reg;
    logic [LVL_W-1:0]    floor_reg;
    logic [LVL_W-1:0]    ceil_reg;
    logic [LVL_W-1:0]    slew_reg;
    logic [LVL_W-1:0]    minstep_reg;

    // control and state
    logic [3:0]          state_reg,   state_next;
    logic                issued_reg,  issued_next;
    logic                m_valid_reg, m_valid_next;
    logic                primed_reg,  primed_next;
    logic [SMOOTH_W-1:0] smooth_reg,  smooth_next;
    logic [LVL_W-1:0]    ramp_reg,    ramp_next;

    // word payload
    in_word_t            item_reg,    item_next;
    logic                rej_reg,     rej_next;
    logic [LVL_W-1:0]    norm_reg,    norm_next;
    logic [LVL_W-1:0]    target_reg,  target_next;
    logic [PWM_BITS-1:0] pwm_reg,     pwm_next;
    out_word_t           out_reg,     out_next;

    // arithmetic units
    logic                mul_start;
    logic [ACC_W-1:0]    mul_mcand;
    logic [MPL_W-1:0]    mul_mplier;
    logic [ACC_W-1:0]    mul_init;
    logic [ACC_W-1:0]    mul_acc;
    logic                mul_done;
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic [LVL_W-1:0]    div_quo;
    logic                div_ovf;
    logic                div_done;

    // derived operands
    logic [WEIGHT_W-1:0] w_eff;
    logic [WEIGHT_W-1:0] w_comp;
    logic [ADC_BITS-1:0] fs_eff;
    logic [LVL_W-1:0]    span;
    logic [KMH_W-1:0]    kmh_eff;
    logic                is_mul_state;
    logic                is_div_state;
    logic                rej_now;
    logic [PROD_W-1:0]   step_raw;
    logic [PROD_W-1:0]   step;
    logic [LVL_W-1:0]    diff;
    logic [LVL_W-1:0]    cap;
    logic [3:0]          after_target;

    assign w_eff   = (weight_reg > EMA_W_FULL) ? EMA_W_FULL : weight_reg;
    assign w_comp  = EMA_W_FULL - w_eff;
    assign fs_eff  = (fs_reg == '0) ? ADC_BITS'(1) : fs_reg;
    assign span    = (ceil_reg > floor_reg) ? (ceil_reg - floor_reg) : '0;
    assign kmh_eff = (item_reg.limit_kmh > LIMIT_KMH_MAX) ? LIMIT_KMH_MAX : item_reg.limit_kmh;
    assign rej_now = s_data.sample_fault || (s_data.adc_sample > fs_reg);

    assign is_mul_state = (state_reg == ST_EMA1) || (state_reg == ST_EMA2) ||
                          (state_reg == ST_TMUL) || (state_reg == ST_CMUL) ||
                          (state_reg == ST_SLEW) || (state_reg == ST_PWM);
    assign is_div_state = (state_reg == ST_NORM) || (state_reg == ST_CDIV);
    assign mul_start    = is_mul_state && !issued_reg;
    assign div_start    = is_div_state && !issued_reg;

    assign after_target = (item_reg.elapsed_ms != '0) ? ST_SLEW : ST_PWM;

    // multiplier operand select
    always_comb begin
        mul_mcand  = '0;
        mul_mplier = '0;
        mul_init   = '0;
        unique case (state_reg)
            ST_EMA1: begin
                mul_mcand  = ACC_W'({item_reg.adc_sample, 8'd0});
                mul_mplier = MPL_W'(w_eff);
                mul_init   = ACC_W'(EMA_ROUND);
            end
            ST_EMA2: begin
                mul_mcand  = ACC_W'(smooth_reg);
                mul_mplier = MPL_W'(w_comp);
                mul_init   = mul_acc;
            end
            ST_TMUL: begin
                mul_mcand  = ACC_W'(norm_reg);
                mul_mplier = span;
                mul_init   = ACC_W'(ROUND_HALF);
            end
            ST_CMUL: begin
                mul_mcand  = ACC_W'(span);
                mul_mplier = MPL_W'(kmh_eff);
            end
            ST_SLEW: begin
                mul_mcand  = ACC_W'(slew_reg);
                mul_mplier = item_reg.elapsed_ms;
            end
            ST_PWM: begin
                mul_mcand  = ACC_W'(ramp_reg);
                mul_mplier = MPL_W'(PWM_MAX);
                mul_init   = ACC_W'(ROUND_HALF);
            end
            default: begin
            end
        endcase
    end

    // divider operand select: average normalize or zone cap over 120
    always_comb begin
        if (state_reg == ST_CDIV) begin
            div_num = NUM_W'(mul_acc);
            div_den = DEN_W'(LIMIT_KMH_MAX);
        end else begin
            div_num = {smooth_reg, {LVL_W{1'b0}}} - NUM_W'(smooth_reg);
            div_den = {fs_eff, 8'd0};
        end
    end

    // slew step
    assign step_raw = mul_acc[PROD_W-1:0];
    assign step     = (step_raw < PROD_W'(minstep_reg)) ? PROD_W'(minstep_reg) : step_raw;
    assign diff     = (target_reg > ramp_reg) ? (target_reg - ramp_reg) : (ramp_reg - target_reg);
    assign cap      = floor_reg + div_quo;

    always_comb begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        m_valid_next = m_valid_reg && !m_ready;
        primed_next  = primed_reg;
        smooth_next  = smooth_reg;
        ramp_next    = ramp_reg;
        item_next    = item_reg;
        rej_next     = rej_reg;
        norm_next    = norm_reg;
        target_next  = target_reg;
        pwm_next     = pwm_reg;
        out_next     = out_reg;

        if (mul_start || div_start) begin
            issued_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    rej_next  = rej_now;
                    if (rej_now) begin
                        target_next = floor_reg;
                        state_next  = (s_data.elapsed_ms != '0) ? ST_SLEW : ST_PWM;
                    end else if (!primed_reg) begin
                        // first accepted sample loads the average directly
                        smooth_next = {s_data.adc_sample, 8'd0};
                        primed_next = 1'b1;
                        state_next  = ST_NORM;
                    end else begin
                        state_next  = ST_EMA1;
                    end
                end
            end
            ST_EMA1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_EMA2;
                end
            end
            ST_EMA2: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    smooth_next = mul_acc[SMOOTH_W+7:8];
                    state_next  = ST_NORM;
                end
            end
            ST_NORM: begin
                if (div_done) begin
                    issued_next = 1'b0;
                    norm_next   = div_ovf ? LVL_MAX : div_quo;
                    state_next  = ST_TMUL;
                end
            end
            ST_TMUL: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    target_next = floor_reg + div_by_lvl_max(mul_acc[PROD_W-1:0]);
                    state_next  = item_reg.limit_active ? ST_CMUL : after_target;
                end
            end
            ST_CMUL: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    state_next  = ST_CDIV;
                end
            end
            ST_CDIV: begin
                if (div_done) begin
                    issued_next = 1'b0;
                    if (cap < target_reg) begin
                        target_next = cap;
                    end
                    state_next = after_target;
                end
            end
            ST_SLEW: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    if (PROD_W'(diff) <= step) begin
                        ramp_next = target_reg;
                    end else if (target_reg > ramp_reg) begin
                        ramp_next = ramp_reg + step[LVL_W-1:0];
                    end else begin
                        ramp_next = ramp_reg - step[LVL_W-1:0];
                    end
                    state_next = ST_PWM;
                end
            end
            ST_PWM: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    pwm_next    = PWM_BITS'(div_by_lvl_max(mul_acc[PROD_W-1:0]));
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.pwm_duty        = pwm_reg;
                    out_next.target_level    = target_reg;
                    out_next.ramp_level      = ramp_reg;
                    out_next.sample_rejected = rej_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            primed_reg  <= 1'b0;
            smooth_reg  <= '0;
            ramp_reg    <= FLOOR_RST;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
            primed_reg  <= primed_next;
            smooth_reg  <= smooth_next;
            ramp_reg    <= ramp_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        rej_reg    <= rej_next;
        norm_reg   <= norm_next;
        target_reg <= target_next;
        pwm_reg    <= pwm_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg  <= EMA_W_RST;
            fs_reg      <= FULL_SCALE_RST;
            floor_reg   <= FLOOR_RST;
            ceil_reg    <= CEILING_RST;
            slew_reg    <= SLEW_RST;
            minstep_reg <= MIN_STEP_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_EMA_WEIGHT:    weight_reg  <= cfg_wdata[WEIGHT_W-1:0];
                CFG_ADC_FULL:      fs_reg      <= cfg_wdata[ADC_BITS-1:0];
                CFG_DUTY_FLOOR:    floor_reg   <= cfg_wdata[LVL_W-1:0];
                CFG_DUTY_CEILING:  ceil_reg    <= cfg_wdata[LVL_W-1:0];
                CFG_SLEW_PER_MS:   slew_reg    <= cfg_wdata[LVL_W-1:0];
                CFG_SLEW_MIN_STEP: minstep_reg <= cfg_wdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ptrp_mul #(
        .ACC_W (ACC_W),
        .MPL_W (MPL_W)
    ) u_mul (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mul_start),
        .mcand    (mul_mcand),
        .mplier   (mul_mplier),
        .acc_init (mul_init),
        .acc      (mul_acc),
        .done     (mul_done)
    );

    ptrp_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .QUO_W (LVL_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .ovf     (div_ovf),
        .done    (div_done)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    // ramp level moves only at the end of a slew step
    a_ramp_only_in_slew: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(ramp_reg) |-> $past(state_reg) == ST_SLEW)
        else $error("ramp level changed outside the slew step");

    // a new result appears only from the output state
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the output state");

    a_mul_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> is_mul_state && issued_reg)
        else $error("multiplier finished with no multiply pending");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_NORM || state_reg == ST_CDIV) && issued_reg)
        else $error("divider finished with no divide pending");
`endif

endmodule

### tb/sv/pedal_throttle_ramp_pwm_test.sv
`timescale 1ns / 1ps

module pedal_throttle_ramp_pwm_test;
    import ptrp_pkg::*;

    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 300;

    class duty_scoreboard;
        logic [WEIGHT_W-1:0] w_ema;
        logic [ADC_BITS-1:0] fs_adc;
        logic [LVL_W-1:0]    lvl_floor;
        logic [LVL_W-1:0]    lvl_ceil;
        logic [LVL_W-1:0]    slew_rate;
        logic [LVL_W-1:0]    step_min;
        logic [SMOOTH_W-1:0] avg_q8;
        logic [LVL_W-1:0]    ramp_now;
        bit                  primed;
        out_word_t           due_results[$];
        int                  errors;

        function new();
            w_ema     = EMA_W_RST;
            fs_adc    = FULL_SCALE_RST;
            lvl_floor = FLOOR_RST;
            lvl_ceil  = CEILING_RST;
            slew_rate = SLEW_RST;
            step_min  = MIN_STEP_RST;
            avg_q8    = '0;
            ramp_now  = FLOOR_RST;
            primed    = 1'b0;
            errors    = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_EMA_WEIGHT:    w_ema     = val[WEIGHT_W-1:0];
                CFG_ADC_FULL:      fs_adc    = val[ADC_BITS-1:0];
                CFG_DUTY_FLOOR:    lvl_floor = val;
                CFG_DUTY_CEILING:  lvl_ceil  = val;
                CFG_SLEW_PER_MS:   slew_rate = val;
                CFG_SLEW_MIN_STEP: step_min  = val;
                default: ;
            endcase
        endfunction

        // predicts the result of one accepted input word and advances the state
        function void take_word(in_word_t w);
            longint unsigned x, wt, fs, avg, norm, span, tgt, cap, kmh;
            longint unsigned step, diff, ramp, flr, ms;
            out_word_t e;
            flr  = lvl_floor;
            span = (lvl_ceil > lvl_floor) ? lvl_ceil - lvl_floor : 0;
            ramp = ramp_now;
            e.sample_rejected = w.sample_fault || (w.adc_sample > fs_adc);
            if (e.sample_rejected) begin
                tgt = flr;
            end else begin
                x = w.adc_sample;
                x = x << 8;
                wt = (w_ema > 9'd256) ? 256 : w_ema;
                fs = (fs_adc == '0) ? 1 : fs_adc;
                avg = avg_q8;
                if (!primed) begin
                    avg = x;
                    primed = 1'b1;
                end else begin
                    avg = (wt * x + (256 - wt) * avg + 128) >> 8;
                end
                avg_q8 = SMOOTH_W'(avg);
                norm = (avg * 65535) / (fs * 256);
                if (norm > 65535) norm = 65535;
                tgt = flr + (norm * span + 32767) / 65535;
                if (w.limit_active) begin
                    kmh = w.limit_kmh;
                    if (kmh > 120) kmh = 120;
                    cap = flr + (kmh * span) / 120;
                    if (cap < tgt) tgt = cap;
                end
            end
            ms = w.elapsed_ms;
            if (ms != 0) begin
                step = slew_rate;
                step = step * ms;
                if (step < step_min) step = step_min;
                diff = (tgt > ramp) ? tgt - ramp : ramp - tgt;
                if (diff <= step) begin
                    ramp = tgt;
                end else if (tgt > ramp) begin
                    ramp = ramp + step;
                end else begin
                    ramp = ramp - step;
                end
            end
            ramp_now = LVL_W'(ramp);
            e.target_level = LVL_W'(tgt);
            e.ramp_level = ramp_now;
            e.pwm_duty = PWM_BITS'((ramp * PWM_MAX + 32767) / 65535);
            due_results.push_back(e);
        endfunction

        function void check_result(out_word_t got);
            out_word_t e;
            if (due_results.size() == 0) begin
                $error("result word %h arrived with nothing expected", got);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if (got.pwm_duty !== e.pwm_duty) begin
                $error("pwm_duty: expected %0d, got %0d", e.pwm_duty, got.pwm_duty);
                errors++;
            end
            if (got.target_level !== e.target_level) begin
                $error("target_level: expected %0d, got %0d", e.target_level, got.target_level);
                errors++;
            end
            if (got.ramp_level !== e.ramp_level) begin
                $error("ramp_level: expected %0d, got %0d", e.ramp_level, got.ramp_level);
                errors++;
            end
            if (got.sample_rejected !== e.sample_rejected) begin
                $error("sample_rejected: expected %0d, got %0d", e.sample_rejected,
                       got.sample_rejected);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;

    duty_scoreboard sb = new();
    bit no_idle = 1'b0;
    int hold_left = 0;

    pedal_throttle_ramp_pwm dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("status: fail");
        $finish;
    end

    // result side: random stall bursts plus one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) sb.check_result(m_data);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_word_t pedal_word(int smp, bit flt, int ms, bit lim, int kmh);
        in_word_t w;
        w.adc_sample   = ADC_BITS'(smp);
        w.sample_fault = flt;
        w.elapsed_ms   = LVL_W'(ms);
        w.limit_active = lim;
        w.limit_kmh    = KMH_W'(kmh);
        return w;
    endfunction

    // leaves cfg_we high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_regs(input logic [15:0] wt, input logic [15:0] fs,
                                input logic [15:0] flr, input logic [15:0] cl,
                                input logic [15:0] sl, input logic [15:0] stp);
        write_reg(CFG_EMA_WEIGHT, wt);
        write_reg(CFG_ADC_FULL, fs);
        write_reg(CFG_DUTY_FLOOR, flr);
        write_reg(CFG_DUTY_CEILING, cl);
        write_reg(CFG_SLEW_PER_MS, sl);
        write_reg(CFG_SLEW_MIN_STEP, stp);
        cfg_we <= 1'b0;
    endtask

    // valid stays high after acceptance unless a gap follows
    task automatic send_word(input in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.take_word(w);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_program();
        logic [15:0] wt, fs, flr, cl, sl, stp;
        case ($urandom_range(0, 5))
            0: wt = 16'd0;
            1: wt = 16'd1;
            2: wt = 16'd256;
            3: wt = 16'd511;
            default: wt = 16'($urandom_range(1, 256));
        endcase
        case ($urandom_range(0, 4))
            0: fs = 16'd4095;
            1: fs = 16'd1;
            2: fs = 16'($urandom_range(0, 4095));
            default: fs = 16'($urandom_range(2048, 4095));
        endcase
        case ($urandom_range(0, 4))
            0: flr = 16'd0;
            1: flr = 16'd65535;
            2: flr = 16'($urandom);
            default: flr = 16'($urandom_range(0, 20000));
        endcase
        case ($urandom_range(0, 4))
            0: cl = 16'd65535;
            1: cl = 16'($urandom);
            2: cl = flr;
            default: cl = 16'($urandom_range(flr, 65535));
        endcase
        case ($urandom_range(0, 4))
            0: sl = 16'd0;
            1: sl = 16'd65535;
            2: sl = 16'($urandom);
            default: sl = 16'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(0, 3))
            0: stp = 16'd0;
            1: stp = 16'd65535;
            default: stp = 16'($urandom_range(0, 500));
        endcase
        program_regs(wt, fs, flr, cl, sl, stp);
    endtask

    // mostly in-range samples with short elapsed times, some noise words
    task automatic random_word();
        in_word_t w;
        w.limit_active = 1'($urandom_range(0, 1));
        w.limit_kmh    = KMH_W'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8) begin
            w.adc_sample   = ADC_BITS'($urandom_range(0, sb.fs_adc));
            w.sample_fault = 1'b0;
        end else begin
            w.adc_sample   = ADC_BITS'($urandom);
            w.sample_fault = 1'($urandom_range(0, 1));
        end
        case ($urandom_range(0, 9))
            0: w.elapsed_ms = '0;
            1, 2: w.elapsed_ms = LVL_W'($urandom);
            default: w.elapsed_ms = LVL_W'($urandom_range(1, 20));
        endcase
        send_word(w);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_idx   <= '0;
        cfg_wdata <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero weight before the first sample: the first sample still loads the average
        write_reg(CFG_EMA_WEIGHT, 16'd0);
        cfg_we <= 1'b0;
        send_word(pedal_word(3000, 0, 0, 0, 0));
        send_word(pedal_word(4095, 0, 1, 0, 0));
        settle();

        program_regs(16'd51, 16'd4095, 16'd0, 16'd65535, 16'd66, 16'd7);
        send_word(pedal_word(4095, 0, 65535, 0, 0));
        send_word(pedal_word(4095, 1, 3, 0, 0));
        send_word(pedal_word(2048, 0, 2, 1, 0));
        send_word(pedal_word(2048, 0, 2, 1, 60));
        send_word(pedal_word(4095, 0, 65535, 1, 120));
        send_word(pedal_word(4095, 0, 65535, 1, 255));
        send_word(pedal_word(100, 0, 0, 1, 200));
        settle();

        // sample over full scale, frozen average, no slew at all
        program_regs(16'd0, 16'd1000, 16'd10000, 16'd50000, 16'd0, 16'd0);
        send_word(pedal_word(2000, 0, 5, 0, 0));
        send_word(pedal_word(1000, 0, 5, 0, 0));
        send_word(pedal_word(999, 0, 1, 1, 130));
        settle();

        // weight over 256, zero full scale, ceiling under floor, huge steps
        program_regs(16'd511, 16'd0, 16'd40000, 16'd20000, 16'd65535, 16'd65535);
        send_word(pedal_word(0, 0, 65535, 0, 0));
        send_word(pedal_word(1, 0, 1, 0, 0));
        send_word(pedal_word(0, 1, 1, 1, 50));
        settle();

        program_regs(16'd256, 16'd4095, 16'd0, 16'd65535, 16'd1, 16'd65535);
        send_word(pedal_word(4095, 0, 1, 0, 0));
        send_word(pedal_word(0, 0, 1, 0, 0));
        send_word(pedal_word(4095, 0, 7, 1, 119));
        settle();

        // floor raised to the top while the ramp sits low
        program_regs(16'd1, 16'd4095, 16'd65535, 16'd65535, 16'd65535, 16'd0);
        send_word(pedal_word(4095, 0, 0, 0, 0));
        send_word(pedal_word(0, 0, 1, 0, 0));

        for (int p = 0; p < PHASES; p++) begin
            settle();
            if (p == 0) begin
                program_regs(16'd51, 16'd4095, 16'd0, 16'd65535, 16'd66, 16'd7);
            end else begin
                random_program();
            end
            no_idle = (p == PHASES - 1);
            if (p == 1) hold_left = HOLD_CYCLES;
            repeat (PHASE_WORDS) random_word();
        end
        settle();

        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### pedal_throttle_ramp_pwm.f
design/ptrp_pkg.sv
design/ptrp_mul.sv
design/ptrp_div.sv
design/pedal_throttle_ramp_pwm.sv
tb/sv/pedal_throttle_ramp_pwm_test.sv
